@@ rtl/core/bb5_pkg.sv @@
// bb5_pkg: constants, types and state codes for the 5x5 rgb box blur
// no dependencies; imported by box_blur_5x5_rgb
`default_nettype none

package bb5_pkg;

  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned Radius   = 2;
  localparam int unsigned NumRows  = 3 * Radius + 1;
  localparam int unsigned Win      = 2 * Radius + 1;

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned SlotW = $clog2(NumRows);
  localparam int unsigned AddrW = SlotW + ColW;
  localparam int unsigned MemDepth = NumRows * MaxWidth;
  localparam int unsigned WinW  = $clog2(Win);
  localparam int unsigned CntW  = $clog2(Win * Win + 1);
  localparam int unsigned SumW  = $clog2(255 * Win * Win + 1);
  localparam int unsigned DivCntW = $clog2(SumW + 1);

  localparam int unsigned FwW  = 11;
  localparam int unsigned FhW  = 16;
  localparam int unsigned LinW = FwW + FhW + 1;

  localparam logic [FwW-1:0] FwReset = 11'd640;
  localparam logic [FhW-1:0] FhReset = 16'd480;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CHK  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_DEC  = 7'b0001000,
    ST_GATH = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_PUT  = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/box_blur_5x5_rgb.sv @@
// box_blur_5x5_rgb: streaming 5x5 mean blur of rgb pixels, raster order
// depends on bb5_pkg
`default_nettype none

// Each request carries one rgb pixel or a flush. Pixels are written to a
// line store of seven rows (one synchronous ram, one write and one read port)
// and each result is the truncated mean of the in-frame part of the 5x5
// neighborhood, emitted two rows plus two pixels after its pixel, in raster
// order. After the last pixel of a frame, flush requests drain the remaining
// results; the last one carries frame_last. A flush before all pixels are in
// gives no result, and a pixel after that is dropped and drains like a flush.
// A request that gives no result passes only check, multiply and decide; one
// that gives a result then walks the 25 window positions one per cycle,
// reading in-frame pixels through the single ram read port, and divides the
// three channel sums by the neighbor count bit-serially, one divider each.
// The input is taken while an earlier result still waits in the output
// register. The user must write geometry through the apb port while idle;
// the block does not enforce this. Width clamps to 1..1024; height 0 counts as 1.

module box_blur_5x5_rgb import bb5_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // pixel request
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  input  wire logic        flush_i,
  // result request
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic             frame_last_o
);

  // configuration registers
  logic [FwW-1:0] frame_width_q;
  logic [FhW-1:0] frame_height_q;
  logic           cfg_we;
  reg_idx_e       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FwReset;
      frame_height_q <= FhReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FwW-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[FhW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = {{(32-FwW){1'b0}}, frame_width_q};
      REG_FRAME_HEIGHT: prdata = {{(32-FhW){1'b0}}, frame_height_q};
      default:          prdata = '0;
    endcase
  end

  // effective geometry: width clamped to 1..max, height zero counts as one
  logic [FwW-1:0] eff_w;
  logic [FhW-1:0] eff_h;
  always_comb begin
    if (frame_width_q == '0) eff_w = FwW'(1);
    else if (frame_width_q > FwW'(MaxWidth)) eff_w = FwW'(MaxWidth);
    else eff_w = frame_width_q;
    eff_h = (frame_height_q == '0) ? FhW'(1) : frame_height_q;
  end

  // control and counters
  state_e state_q, state_d;
  logic [ColW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [FhW-1:0]   in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SlotW-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic [LinW-1:0]  in_lin_q, out_lin_q, area_q;
  logic             last_q, last_d;

  // captured request payload
  logic [23:0] pix_q;
  logic        flush_q;

  // window gather
  logic [WinW-1:0] dy_q, dy_d, dx_q, dx_d;
  logic            gdone_q, gdone_d;
  logic            rd_vld_q;
  logic [23:0]     rd_data_q;
  logic [SumW-1:0] sr_q, sg_q, sb_q;
  logic [CntW-1:0] cnt_q;
  logic            clr_acc;

  // divider
  logic [SumW-1:0]    qr_q, qg_q, qb_q;
  logic [CntW-1:0]    rr_q, rg_q, rb_q;
  logic [DivCntW-1:0] dcnt_q;
  logic               div_start;

  // output register
  logic       out_valid_q;
  logic [7:0] ro_q, go_q, bo_q;
  logic       fl_q;
  logic       out_load;

  // ram ports
  logic              mem_we;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic              issue, nb_ok;
  logic [23:0]       row_mem [MemDepth];

  assign in_ready_o = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // combinational next state
  // --------------------------------------------------------------------------
  logic           restart_a;
  logic           restart_b;
  logic [LinW-1:0] il, ol, il_inc, lag;
  logic           emit;
  logic [FhW:0]   row_t;
  logic [ColW:0]  col_t;
  logic [SlotW+2:0] slot_t;

  always_comb begin
    state_d    = state_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    last_d     = last_q;
    dy_d       = dy_q;
    dx_d       = dx_q;
    gdone_d    = gdone_q;
    mem_we     = 1'b0;
    wr_addr    = {in_slot_q, in_col_q};
    clr_acc    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    emit       = 1'b0;

    // position checks against geometry
    restart_a = (in_row_q > eff_h) ||
                ((in_row_q == eff_h) && (in_col_q != '0)) ||
                ((in_row_q < eff_h) && ({1'b0, in_col_q} >= eff_w)) ||
                (out_row_q >= eff_h) || ({1'b0, out_col_q} >= eff_w);
    restart_b = out_lin_q > in_lin_q;
    il     = restart_b ? '0 : in_lin_q;
    ol     = restart_b ? '0 : out_lin_q;
    il_inc = il + LinW'(1);
    lag    = LinW'(eff_w) * LinW'(Radius) + LinW'(Radius);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHK;
      end
      ST_CHK: begin
        if (restart_a) begin
          in_col_d = '0; in_row_d = '0; in_slot_d = '0;
          out_col_d = '0; out_row_d = '0; out_slot_d = '0;
        end
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_DEC;
      end
      ST_DEC: begin
        if (restart_b) begin
          in_col_d = '0; in_row_d = '0; in_slot_d = '0;
          out_col_d = '0; out_row_d = '0; out_slot_d = '0;
        end
        if ((restart_b ? '0 : in_row_q) < eff_h) begin
          if (!flush_q) begin
            mem_we  = 1'b1;
            wr_addr = restart_b ? '0 : {in_slot_q, in_col_q};
            if ({1'b0, in_col_d} + 1'b1 >= eff_w) begin
              in_col_d  = '0;
              in_row_d  = in_row_d + 1'b1;
              in_slot_d = (in_slot_d == SlotW'(NumRows - 1)) ? '0 : in_slot_d + 1'b1;
            end else begin
              in_col_d = in_col_d + 1'b1;
            end
            emit = (il_inc - ol) > lag;
          end
        end else begin
          emit = 1'b1;
        end
        last_d  = (ol == area_q - LinW'(1));
        dy_d    = '0;
        dx_d    = '0;
        gdone_d = 1'b0;
        clr_acc = 1'b1;
        state_d = emit ? ST_GATH : ST_IDLE;
      end
      ST_GATH: begin
        if (!gdone_q) begin
          if (dx_q == WinW'(Win - 1)) begin
            dx_d = '0;
            if (dy_q == WinW'(Win - 1)) gdone_d = 1'b1;
            else dy_d = dy_q + 1'b1;
          end else begin
            dx_d = dx_q + 1'b1;
          end
        end else begin
          // last read lands in the sums at this edge
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt_q == DivCntW'(SumW - 1)) state_d = ST_PUT;
      end
      ST_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (last_q) begin
            in_col_d = '0; in_row_d = '0; in_slot_d = '0;
            out_col_d = '0; out_row_d = '0; out_slot_d = '0;
          end else if ({1'b0, out_col_q} + 1'b1 >= eff_w) begin
            out_col_d  = '0;
            out_row_d  = out_row_q + 1'b1;
            out_slot_d = (out_slot_q == SlotW'(NumRows - 1)) ? '0 : out_slot_q + 1'b1;
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // neighbor address: row slot (out_slot + dy - radius) mod rows, column out_col + dx - radius
  always_comb begin
    row_t  = {1'b0, out_row_q} + (FhW+1)'(dy_q);
    col_t  = {1'b0, out_col_q} + (ColW+1)'(dx_q);
    slot_t = (SlotW+3)'(out_slot_q) + (SlotW+3)'(dy_q) + (SlotW+3)'(NumRows - Radius);
    if (slot_t >= (SlotW+3)'(NumRows)) slot_t = slot_t - (SlotW+3)'(NumRows);
    if (slot_t >= (SlotW+3)'(NumRows)) slot_t = slot_t - (SlotW+3)'(NumRows);
    nb_ok = (row_t >= (FhW+1)'(Radius)) &&
            ((row_t - (FhW+1)'(Radius)) < {1'b0, eff_h}) &&
            (col_t >= (ColW+1)'(Radius)) &&
            ((col_t - (ColW+1)'(Radius)) < eff_w);
    rd_addr = {slot_t[SlotW-1:0], col_t[ColW-1:0] - ColW'(Radius)};
    issue   = (state_q == ST_GATH) && !gdone_q;
  end

  // --------------------------------------------------------------------------
  // line store ram
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[wr_addr] <= pix_q;
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= row_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      last_q      <= 1'b0;
      dy_q        <= '0;
      dx_q        <= '0;
      gdone_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      last_q     <= last_d;
      dy_q       <= dy_d;
      dx_q       <= dx_d;
      gdone_q    <= gdone_d;
      rd_vld_q   <= issue & nb_ok;
      if (div_start) dcnt_q <= '0;
      else if (state_q == ST_DIV) dcnt_q <= dcnt_q + 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pix_q   <= {red_in_i, green_in_i, blue_in_i};
      flush_q <= flush_i;
    end
    // linear positions and frame area
    if (state_q == ST_MUL) begin
      in_lin_q  <= LinW'(in_row_q) * LinW'(eff_w) + LinW'(in_col_q);
      out_lin_q <= LinW'(out_row_q) * LinW'(eff_w) + LinW'(out_col_q);
      area_q    <= LinW'(eff_w) * LinW'(eff_h);
    end
    // window sums
    if (clr_acc) begin
      sr_q  <= '0;
      sg_q  <= '0;
      sb_q  <= '0;
      cnt_q <= '0;
    end else if (rd_vld_q) begin
      sr_q  <= sr_q + SumW'(rd_data_q[23:16]);
      sg_q  <= sg_q + SumW'(rd_data_q[15:8]);
      sb_q  <= sb_q + SumW'(rd_data_q[7:0]);
      cnt_q <= cnt_q + 1'b1;
    end
    // restoring divide, one quotient bit per cycle for all three channels
    if (div_start) begin
      rr_q <= '0;
      rg_q <= '0;
      rb_q <= '0;
    end else if (state_q == ST_DIV) begin
      if ({rr_q, qr_q[SumW-1]} >= {1'b0, cnt_q}) begin
        rr_q <= CntW'({rr_q, qr_q[SumW-1]} - {1'b0, cnt_q});
        qr_q <= {qr_q[SumW-2:0], 1'b1};
      end else begin
        rr_q <= CntW'({rr_q, qr_q[SumW-1]});
        qr_q <= {qr_q[SumW-2:0], 1'b0};
      end
      if ({rg_q, qg_q[SumW-1]} >= {1'b0, cnt_q}) begin
        rg_q <= CntW'({rg_q, qg_q[SumW-1]} - {1'b0, cnt_q});
        qg_q <= {qg_q[SumW-2:0], 1'b1};
      end else begin
        rg_q <= CntW'({rg_q, qg_q[SumW-1]});
        qg_q <= {qg_q[SumW-2:0], 1'b0};
      end
      if ({rb_q, qb_q[SumW-1]} >= {1'b0, cnt_q}) begin
        rb_q <= CntW'({rb_q, qb_q[SumW-1]} - {1'b0, cnt_q});
        qb_q <= {qb_q[SumW-2:0], 1'b1};
      end else begin
        rb_q <= CntW'({rb_q, qb_q[SumW-1]});
        qb_q <= {qb_q[SumW-2:0], 1'b0};
      end
    end
    if (state_q == ST_GATH && gdone_q) begin
      // dividends: sums including the read landing this cycle
      qr_q <= rd_vld_q ? sr_q + SumW'(rd_data_q[23:16]) : sr_q;
      qg_q <= rd_vld_q ? sg_q + SumW'(rd_data_q[15:8])  : sg_q;
      qb_q <= rd_vld_q ? sb_q + SumW'(rd_data_q[7:0])   : sb_q;
    end
    if (out_load) begin
      ro_q <= qr_q[7:0];
      go_q <= qg_q[7:0];
      bo_q <= qb_q[7:0];
      fl_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = ro_q;
  assign green_out_o  = go_q;
  assign blue_out_o   = bo_q;
  assign frame_last_o = fl_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the divisor always holds at least the center pixel
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != '0))
    else $error("divide by zero neighbor count");

  // never more neighbors than the window holds
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q <= CntW'(Win * Win)))
    else $error("neighbor count above window size");

  // a result is loaded only when the output register is free or being drained
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
